>>> src/twrsm_pkg.sv
// Shared types and constants for the three-wire serial master.
// Holds the item, result, configuration and queue-head structs; every module uses it.
// Depends on nothing.
package twrsm_pkg;

    localparam int DATA_BITS = 8;
    localparam int TICK_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = TICK_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_SETUP_TICKS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_BIT_TICKS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TICKS     = 2'd2;

    localparam logic [TICK_W-1:0] SETUP_TICKS_RST    = 8'd4;
    localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = 8'd1;
    localparam logic [TICK_W-1:0] HOLD_TICKS_RST     = 8'd4;

    // Bit 0 of the command byte selects a read transaction.
    localparam int READ_FLAG_BIT = 0;

    typedef struct packed {
        logic [TICK_W-1:0] setup_ticks;
        logic [TICK_W-1:0] half_bit_ticks;
        logic [TICK_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 start_req;
        logic [DATA_BITS-1:0] command_byte;
        logic [COUNT_W-1:0]   byte_count;
        logic [DATA_BITS-1:0] write_data;
        logic                 io_sample;
    } item_t;

    typedef struct packed {
        logic                 ce_level;
        logic                 pins_driven;
        logic                 sclk_level;
        logic                 io_level;
        logic                 io_driven;
        logic [DATA_BITS-1:0] read_byte;
        logic                 read_valid;
        logic                 write_taken;
        logic                 busy_res;
    } result_t;

    // Handshake between the input queue and the sequencer.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

>>> src/three_wire_rtc_serial_master.sv
// Top level of the three-wire serial master: stream ports, configuration registers,
// input queue and pin sequencer.
// Depends on twrsm_pkg, twrsm_front and twrsm_seq.
//
// Usage: every item on the slave stream is one time tick of the pin sequencer and
// produces exactly one item on the master stream, in order. An input item carries a
// start request in s_tuser and the command byte, byte count, next write byte and the
// sampled data pin level in s_tdata. The output item gives the chip enable, clock and
// data pin levels, the data pin direction, a completed read byte with its flag, a
// write-byte-taken flag and the busy flag.
// An accepted item is written into the input queue and then stepped into the result
// register. Throughput is one item per cycle while m_tready stays high; the
// sequencer steps once per cycle unless a result waits untaken, and the queue
// keeps taking items while a result waits. When the receiver stalls, the result
// register holds, the sequencer stops, and the queue fills; s_tready drops once
// QUEUE_DEPTH items are waiting. Reset clears the queue, returns the sequencer to
// idle with all pins released, and loads the tick registers with setup 4, half
// bit 1 and hold 4. The user writes registers through cfg_wr_en/cfg_addr/cfg_wdata
// only while no transaction is in progress; the block does not enforce this.
module three_wire_rtc_serial_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: command_byte[7:0], byte_count[12:8], write_data[20:13],
    // io_sample[21], zero fill [23:22]
    input  logic [23:0]                         s_tdata,
    // s_tuser: start_req[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: ce_level[0], pins_driven[1], sclk_level[2], io_level[3],
    // io_driven[4], read_byte[12:5], read_valid[13], write_taken[14], busy_res[15]
    output logic [15:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [twrsm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [twrsm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    twrsm_pkg::cfg_t        cfg_reg;
    twrsm_pkg::item_t       in_item;
    twrsm_pkg::queue_head_t head;
    twrsm_pkg::result_t     m_res;
    logic                   pop;

    // Configuration registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks    <= twrsm_pkg::SETUP_TICKS_RST;
            cfg_reg.half_bit_ticks <= twrsm_pkg::HALF_BIT_TICKS_RST;
            cfg_reg.hold_ticks     <= twrsm_pkg::HOLD_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                twrsm_pkg::CFG_SETUP_TICKS:    cfg_reg.setup_ticks    <= cfg_wdata;
                twrsm_pkg::CFG_HALF_BIT_TICKS: cfg_reg.half_bit_ticks <= cfg_wdata;
                twrsm_pkg::CFG_HOLD_TICKS:     cfg_reg.hold_ticks     <= cfg_wdata;
                default:                       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Unpack the slave stream into the item fields.
    assign in_item.start_req    = s_tuser;
    assign in_item.command_byte = s_tdata[7:0];
    assign in_item.byte_count   = s_tdata[12:8];
    assign in_item.write_data   = s_tdata[20:13];
    assign in_item.io_sample    = s_tdata[21];

    twrsm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .head     (head),
        .pop      (pop)
    );

    twrsm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (m_res)
    );

    // Pack the result fields onto the master stream.
    assign m_tdata = {m_res.busy_res, m_res.write_taken, m_res.read_valid, m_res.read_byte,
                      m_res.io_driven, m_res.io_level, m_res.sclk_level,
                      m_res.pins_driven, m_res.ce_level};

`ifndef SYNTHESIS
    // A completed read byte only appears while the data pin is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.read_valid) |-> !m_res.io_driven)
        else $error("read byte reported while data pin driven");

    // A write byte is taken only with chip enable high and the data pin driven.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.write_taken) |-> (m_res.ce_level && m_res.io_driven))
        else $error("write byte taken outside an active write");

    // Outside a transaction every pin is released and low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_res.busy_res) |->
            (!m_res.ce_level && !m_res.pins_driven && !m_res.sclk_level &&
             !m_res.io_level && !m_res.io_driven))
        else $error("pins active while idle");
`endif

endmodule

>>> src/twrsm_front.sv
// Input side of the serial master: a small item queue in front of the sequencer.
// Accepts items from the stream port and hands them out in order.
// Depends on twrsm_pkg.
module twrsm_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  twrsm_pkg::item_t       in_item,
    output twrsm_pkg::queue_head_t head,
    input  logic                   pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    twrsm_pkg::item_t slot_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign in_ready   = (count_reg != FULL_CNT);
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> src/twrsm_seq.sv
// Back end of the serial master: the pin sequencer and its result register.
// Each queued item is one time tick; the tick updates the state and yields one result.
// Depends on twrsm_pkg.
module twrsm_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  twrsm_pkg::cfg_t        cfg,
    input  twrsm_pkg::queue_head_t head,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output twrsm_pkg::result_t     res
);

    localparam int DB = twrsm_pkg::DATA_BITS;
    localparam int BI_W = $clog2(DB);
    localparam logic [BI_W-1:0] LAST_BIT = BI_W'(DB - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_WSET,
        PH_WHIGH,
        PH_WLOW,
        PH_RHIGH,
        PH_RLOW,
        PH_HOLD
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [twrsm_pkg::TICK_W-1:0]     wait_reg, wait_next;
    logic [BI_W-1:0]                  bit_reg, bit_next;
    logic [twrsm_pkg::COUNT_W-1:0]    left_reg, left_next;
    logic [DB-1:0]                    shift_reg, shift_next;
    logic                             is_read_reg, is_read_next;
    logic                             in_cmd_reg, in_cmd_next;
    logic                             io_out_reg, io_out_next;
    logic                             res_valid_reg;
    twrsm_pkg::result_t               res_reg, res_next;

    logic [twrsm_pkg::COUNT_W-1:0]    left_after;
    logic [DB-1:0]                    shift_down;
    logic [BI_W-1:0]                  bit_inc;
    twrsm_pkg::item_t                 it;

    // A tick count of zero behaves as one.
    function automatic logic [twrsm_pkg::TICK_W-1:0] fix_ticks(
        input logic [twrsm_pkg::TICK_W-1:0] t
    );
        return (t == '0) ? twrsm_pkg::TICK_W'(1) : t;
    endfunction

    assign it        = head.item;
    assign pop       = head.valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        bit_next     = bit_reg;
        left_next    = left_reg;
        shift_next   = shift_reg;
        is_read_next = is_read_reg;
        in_cmd_next  = in_cmd_reg;
        io_out_next  = io_out_reg;
        res_next     = '0;
        left_after   = left_reg;
        shift_down   = shift_reg >> 1;
        bit_inc      = bit_reg + 1'b1;

        if (phase_reg == PH_IDLE)
        begin
            if (it.start_req)
            begin
                is_read_next = it.command_byte[twrsm_pkg::READ_FLAG_BIT];
                in_cmd_next  = 1'b1;
                left_next    = it.byte_count;
                shift_next   = it.command_byte;
                bit_next     = '0;
                io_out_next  = 1'b0;
                phase_next   = PH_SETUP;
                wait_next    = fix_ticks(cfg.setup_ticks);
            end
        end
        else if (wait_reg > twrsm_pkg::TICK_W'(1))
        begin
            wait_next = wait_reg - 1'b1;
        end
        else if (phase_reg == PH_HOLD)
        begin
            phase_next = PH_IDLE;
            wait_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_SETUP:
                begin
                    bit_next    = '0;
                    io_out_next = shift_reg[0];
                    phase_next  = PH_WSET;
                    wait_next   = fix_ticks(cfg.half_bit_ticks);
                end
                PH_WSET:
                begin
                    phase_next = PH_WHIGH;
                    wait_next  = fix_ticks(cfg.half_bit_ticks);
                end
                PH_WHIGH:
                begin
                    phase_next = PH_WLOW;
                    wait_next  = fix_ticks(cfg.half_bit_ticks);
                end
                PH_RHIGH:
                begin
                    phase_next = PH_RLOW;
                    wait_next  = fix_ticks(cfg.half_bit_ticks);
                end
                PH_WLOW:
                begin
                    shift_next = shift_down;
                    if (bit_reg != LAST_BIT)
                    begin
                        bit_next    = bit_inc;
                        io_out_next = shift_down[0];
                        phase_next  = PH_WSET;
                        wait_next   = fix_ticks(cfg.half_bit_ticks);
                    end
                    else
                    begin
                        bit_next = '0;
                        // The command byte does not count against the data bytes.
                        if (in_cmd_reg)
                        begin
                            in_cmd_next = 1'b0;
                        end
                        else if (left_reg != '0)
                        begin
                            left_after = left_reg - 1'b1;
                        end
                        left_next = left_after;
                        if (left_after != '0)
                        begin
                            if (is_read_reg)
                            begin
                                shift_next = DB'(it.io_sample);
                                phase_next = PH_RHIGH;
                            end
                            else
                            begin
                                shift_next           = it.write_data;
                                io_out_next          = it.write_data[0];
                                res_next.write_taken = 1'b1;
                                phase_next           = PH_WSET;
                            end
                            wait_next = fix_ticks(cfg.half_bit_ticks);
                        end
                        else
                        begin
                            phase_next = PH_HOLD;
                            wait_next  = fix_ticks(cfg.hold_ticks);
                        end
                    end
                end
                PH_RLOW:
                begin
                    if (bit_reg != LAST_BIT)
                    begin
                        bit_next   = bit_inc;
                        shift_next = shift_reg | (DB'(it.io_sample) << bit_inc);
                        phase_next = PH_RHIGH;
                        wait_next  = fix_ticks(cfg.half_bit_ticks);
                    end
                    else
                    begin
                        res_next.read_valid = 1'b1;
                        res_next.read_byte  = shift_reg;
                        if (left_reg != '0)
                        begin
                            left_after = left_reg - 1'b1;
                        end
                        left_next = left_after;
                        bit_next  = '0;
                        if (left_after != '0)
                        begin
                            // A read stays a read, so the next byte samples at once.
                            shift_next = DB'(it.io_sample);
                            phase_next = PH_RHIGH;
                            wait_next  = fix_ticks(cfg.half_bit_ticks);
                        end
                        else
                        begin
                            phase_next = PH_HOLD;
                            wait_next  = fix_ticks(cfg.hold_ticks);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    wait_next  = '0;
                end
            endcase
        end

        // Pin levels after this tick's update.
        case (phase_next)
            PH_SETUP:
            begin
                res_next.ce_level    = 1'b1;
                res_next.pins_driven = 1'b1;
                res_next.io_driven   = 1'b1;
            end
            PH_WSET, PH_WHIGH:
            begin
                res_next.ce_level    = 1'b1;
                res_next.pins_driven = 1'b1;
                res_next.io_driven   = 1'b1;
                res_next.io_level    = io_out_next;
                res_next.sclk_level  = (phase_next == PH_WHIGH);
            end
            PH_WLOW:
            begin
                res_next.ce_level    = 1'b1;
                res_next.pins_driven = 1'b1;
                // The data line turns around on the last command bit of a read.
                if (!(in_cmd_next && is_read_next && (bit_next == LAST_BIT)))
                begin
                    res_next.io_driven = 1'b1;
                    res_next.io_level  = io_out_next;
                end
            end
            PH_RHIGH:
            begin
                res_next.ce_level    = 1'b1;
                res_next.pins_driven = 1'b1;
                res_next.sclk_level  = 1'b1;
            end
            PH_RLOW:
            begin
                res_next.ce_level    = 1'b1;
                res_next.pins_driven = 1'b1;
            end
            PH_HOLD:
            begin
                res_next.pins_driven = 1'b1;
                if (!is_read_next)
                begin
                    res_next.io_driven = 1'b1;
                    res_next.io_level  = io_out_next;
                end
            end
            default:
            begin
                res_next.pins_driven = 1'b0;
            end
        endcase
        res_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            bit_reg       <= '0;
            left_reg      <= '0;
            shift_reg     <= '0;
            is_read_reg   <= 1'b0;
            in_cmd_reg    <= 1'b0;
            io_out_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                wait_reg    <= wait_next;
                bit_reg     <= bit_next;
                left_reg    <= left_next;
                shift_reg   <= shift_next;
                is_read_reg <= is_read_next;
                in_cmd_reg  <= in_cmd_next;
                io_out_reg  <= io_out_next;
                res_reg     <= res_next;
            end
            if (pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule
